// File: design/npp_pkg.sv
// Shared constants, state encoding and divider control types for the progression prime search.
package npp_pkg;

	localparam int TERM_BITS  = 32;
	localparam int STEP_BITS  = 32;
	localparam int INDEX_BITS = 20;
	localparam int LIMIT_BITS = 20;

	// Trial divisors never exceed the square root of a term, plus one odd step.
	localparam int DIVR_BITS = TERM_BITS / 2 + 1;
	localparam int ITER_BITS = $clog2(TERM_BITS + 1);

	localparam logic [LIMIT_BITS-1:0] TERM_LIMIT_RESET = LIMIT_BITS'(1000000);
	localparam logic [DIVR_BITS-1:0]  FIRST_DIVISOR    = DIVR_BITS'(3);
	localparam logic [DIVR_BITS-1:0]  DIVISOR_STRIDE   = DIVR_BITS'(2);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TEST,
		ST_DIV,
		ST_HIT,
		ST_ADV,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic                 start;
		logic [TERM_BITS-1:0] dividend;
		logic [DIVR_BITS-1:0] divisor;
	} div_ctl_t;

	typedef struct packed {
		logic                 done;
		logic [TERM_BITS-1:0] quo;
		logic [DIVR_BITS-1:0] rem;
	} div_sts_t;

endpackage

// File: design/npp_ifs.sv
// Valid/ready channel interfaces for request, response and configuration words.
interface npp_req_if;
	import npp_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [TERM_BITS-1:0]  start_req;
	logic [STEP_BITS-1:0]  step;
	logic [INDEX_BITS-1:0] index;
	modport source (output valid, start_req, step, index, input ready);
	modport sink   (input valid, start_req, step, index, output ready);
endinterface

interface npp_rsp_if;
	import npp_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [TERM_BITS-1:0] prime;
	logic                 found;
	modport source (output valid, prime, found, input ready);
	modport sink   (input valid, prime, found, output ready);
endinterface

interface npp_cfg_if;
	import npp_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [LIMIT_BITS-1:0] term_limit;
	modport source (output valid, term_limit, input ready);
	modport sink   (input valid, term_limit, output ready);
endinterface

// File: design/npp_div.sv
// Radix-2 restoring divider that yields quotient and remainder one bit per cycle.
module npp_div (
	input  logic              clk,
	input  logic              arst_n,
	input  npp_pkg::div_ctl_t ctl,
	output npp_pkg::div_sts_t sts
);
	import npp_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [ITER_BITS-1:0] iter_q;
	logic [TERM_BITS-1:0] quo_q;
	logic [DIVR_BITS-1:0] rem_q;
	logic [DIVR_BITS-1:0] divisor_q;
	logic [DIVR_BITS:0]   shifted;
	logic [DIVR_BITS:0]   trial;
	logic                 fits;

	always_comb begin
		shifted = {rem_q, quo_q[TERM_BITS-1]};
		fits    = shifted >= {1'b0, divisor_q};
		trial   = shifted - {1'b0, divisor_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			iter_q <= ITER_BITS'(TERM_BITS);
		end else if (busy_q) begin
			iter_q <= iter_q - ITER_BITS'(1);
			if (iter_q == ITER_BITS'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// The partial remainder stays below the divisor, so its low bits suffice.
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			quo_q     <= ctl.dividend;
			rem_q     <= '0;
			divisor_q <= ctl.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial[DIVR_BITS-1:0] : shifted[DIVR_BITS-1:0];
			quo_q <= {quo_q[TERM_BITS-2:0], fits};
		end
	end

	assign sts.done = done_q;
	assign sts.quo  = quo_q;
	assign sts.rem  = rem_q;

endmodule

// File: design/nth_prime_in_progression_core.sv
// Top level: searches an arithmetic progression for its n-th prime term by trial division.
//
//   channel  role     words carried
//   -------  -------  --------------------------------------------------
//   req      sink     start_req, step, index: one search request
//   rsp      source   prime, found: one answer per request
//   cfg      sink     term_limit: greatest number of terms examined
//
// A request is taken only in the idle state; the block then works on that
// one word until its answer is registered. Each trial division runs through
// one shared bit-serial divider, and the step that hands over a result also
// launches the next divisor. The answer sits in an output register, and a
// stalled rsp only delays the return to idle. Reset clears all control state
// and loads term_limit with 1000000; cfg.ready is always high.
module nth_prime_in_progression_core (
	input logic    clk,
	input logic    arst_n,
	npp_req_if.sink   req,
	npp_rsp_if.source rsp,
	npp_cfg_if.sink   cfg
);
	import npp_pkg::*;

	state_t state_q;
	state_t state_d;

	// Search context.
	logic [TERM_BITS-1:0]  term_q,  term_d;
	logic [STEP_BITS-1:0]  step_q,  step_d;
	logic [INDEX_BITS-1:0] want_q,  want_d;
	logic [INDEX_BITS-1:0] count_q, count_d;
	logic [LIMIT_BITS-1:0] seen_q,  seen_d;
	logic [DIVR_BITS-1:0]  dv_q,    dv_d;
	logic [TERM_BITS-1:0]  res_prime_q, res_prime_d;
	logic                  res_found_q, res_found_d;

	logic [LIMIT_BITS-1:0] limit_q;

	// Output register.
	logic                  out_valid_q;
	logic [TERM_BITS-1:0]  out_prime_q;
	logic                  out_found_q;
	logic                  out_load;

	logic [TERM_BITS:0]    next_sum;
	logic [INDEX_BITS-1:0] count_inc;
	logic [LIMIT_BITS-1:0] seen_inc;
	logic [DIVR_BITS-1:0]  dv_next;

	div_ctl_t div_ctl;
	div_sts_t div_sts;

	npp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.sts    (div_sts)
	);

	// The next term overflows the value width exactly when this sum carries out.
	assign next_sum  = {1'b0, term_q} + {1'b0, step_q};
	assign count_inc = count_q + INDEX_BITS'(1);
	assign seen_inc  = seen_q + LIMIT_BITS'(1);
	assign dv_next   = dv_q + DIVISOR_STRIDE;

	always_comb begin
		state_d          = state_q;
		term_d           = term_q;
		step_d           = step_q;
		want_d           = want_q;
		count_d          = count_q;
		seen_d           = seen_q;
		dv_d             = dv_q;
		res_prime_d      = res_prime_q;
		res_found_d      = res_found_q;
		out_load         = 1'b0;
		div_ctl.start    = 1'b0;
		div_ctl.dividend = term_q;
		div_ctl.divisor  = dv_q;
		req.ready        = (state_q == ST_IDLE);

		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					term_d      = req.start_req;
					step_d      = req.step;
					want_d      = req.index;
					count_d     = '0;
					seen_d      = '0;
					res_prime_d = '0;
					res_found_d = 1'b0;
					// A zero index or a zero limit examines no term at all.
					if (req.index == '0 || limit_q == '0) begin
						state_d = ST_FINISH;
					end else begin
						state_d = ST_TEST;
					end
				end
			end
			ST_TEST: begin
				if (term_q < TERM_BITS'(2)) begin
					state_d = ST_ADV;
				end else if (term_q < TERM_BITS'(4)) begin
					state_d = ST_HIT;
				end else if (!term_q[0]) begin
					state_d = ST_ADV;
				end else begin
					div_ctl.start   = 1'b1;
					div_ctl.divisor = FIRST_DIVISOR;
					dv_d            = FIRST_DIVISOR;
					state_d         = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_sts.done) begin
					// Divisor above the quotient means divisor squared exceeds the term.
					if (TERM_BITS'(dv_q) > div_sts.quo) begin
						state_d = ST_HIT;
					end else if (div_sts.rem == '0) begin
						state_d = ST_ADV;
					end else begin
						div_ctl.start   = 1'b1;
						div_ctl.divisor = dv_next;
						dv_d            = dv_next;
					end
				end
			end
			ST_HIT: begin
				count_d = count_inc;
				if (count_inc == want_q) begin
					res_prime_d = term_q;
					res_found_d = 1'b1;
					state_d     = ST_FINISH;
				end else begin
					state_d = ST_ADV;
				end
			end
			ST_ADV: begin
				if (seen_inc >= limit_q || next_sum[TERM_BITS]) begin
					state_d = ST_FINISH;
				end else begin
					term_d  = next_sum[TERM_BITS-1:0];
					seen_d  = seen_inc;
					state_d = ST_TEST;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		term_q      <= term_d;
		step_q      <= step_d;
		want_q      <= want_d;
		count_q     <= count_d;
		seen_q      <= seen_d;
		dv_q        <= dv_d;
		res_prime_q <= res_prime_d;
		res_found_q <= res_found_d;
	end

	// The user is to write configuration only while the block is idle; the block itself does not enforce this.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= TERM_LIMIT_RESET;
		end else if (cfg.valid) begin
			limit_q <= cfg.term_limit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_prime_q <= res_prime_q;
			out_found_q <= res_found_q;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.prime = out_prime_q;
	assign rsp.found = out_found_q;

endmodule

// File: design/npp_checker.sv
// Port-level checker for the progression prime search, bound to the top level.
module npp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [npp_pkg::TERM_BITS-1:0] rsp_prime,
	input logic                          rsp_found
);
	import npp_pkg::*;

	// A waiting answer holds until it is taken.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_prime) && $stable(rsp_found))
		else $error("response word changed while stalled");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_found |-> rsp_prime == '0)
		else $error("not-found answer carries a nonzero prime");

	a_hit_prime: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_found |-> rsp_prime >= TERM_BITS'(2))
		else $error("found answer below the smallest prime");

	// One request at a time: taking a word closes the request side.
	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request side stayed open after a word was taken");

endmodule

bind nth_prime_in_progression_core npp_checker u_npp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_prime (rsp.prime),
	.rsp_found (rsp.found)
);
